/* design/separable_binomial_blur_3x3_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the separable binomial blur
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SEPARABLE_BINOMIAL_BLUR_3X3_ASSERT_SVH
`define SEPARABLE_BINOMIAL_BLUR_3X3_ASSERT_SVH

// Next-cycle implication, suspended while reset is high
`define SBB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("blur checker: next-cycle property failed");

// Next-cycle implication that also holds through reset
`define SBB_ASSERT_NEXT_ANY(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("blur checker: next-cycle property failed");

// Same-cycle implication that holds at every edge
`define SBB_ASSERT_IMPLY(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("blur checker: same-cycle property failed");

`endif

/* design/sbb_pkg.sv */
// ----------------------------------------------------------------------------
// Separable binomial blur package
// Shared constants, register codes, result record and filter arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package sbb_pkg;

   // Line buffer depth default
   localparam int unsigned DEFAULT_MAX_WIDTH = 4096;

   // Row limit and register reset values
   localparam int unsigned ROW_LIMIT      = 16384;
   localparam logic [12:0] RESET_WIDTH    = 13'd4096;
   localparam logic [14:0] RESET_HEIGHT   = 15'd16384;

   // Configuration port
   localparam int unsigned CSR_DATA_W = 15;
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   // Stream widths
   localparam int unsigned REQ_TDATA_W = 16;
   localparam int unsigned RSP_TDATA_W = 48;
   localparam int unsigned RSP_PAD_W   = 6;

   // Result queue depth (power of two)
   localparam int unsigned OUT_DEPTH = 8;

   typedef struct packed {
      logic        done;
      logic [11:0] col;
      logic [13:0] row;
      logic [15:0] blurred;
   } res_type;

   // Rounded mean of two samples
   function automatic logic [15:0] avg2(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b} + 17'd1;
      return s[16:1];
   endfunction

   // Rounded [1 2 1]/4 of three samples
   function automatic logic [15:0] avg121(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] c);
      logic [17:0] s;
      s = {2'b0, a} + {1'b0, b, 1'b0} + {2'b0, c} + 18'd2;
      return s[17:2];
   endfunction

endpackage

`default_nettype wire

/* design/separable_binomial_blur_3x3.sv */
// ----------------------------------------------------------------------------
// Separable 3x3 binomial blur
// Raster-order [1 2 1]/4 blur (two-tap mean at the frame edges), horizontal then vertical, with line memories.
// ----------------------------------------------------------------------------
// Samples of one plane enter in raster order on req_ and filtered samples
// leave on rsp_ with their row and column; rsp_tlast marks the last result of
// the frame. Each accepted sample becomes up to two column jobs (two only at
// the end of a row), and the column job unit starts one job per cycle while
// the result queue has room for its results: it reads both line memories at
// that column, forms up to two vertical results the next cycle and writes the
// column back. While jobs issue, an ordinary sample is taken every cycle and
// the last sample of a row holds off the next until its second job issues.
// In the last row each column gives two results, one for each of the final
// two rows, so there the result port's one result per cycle sets the rate.
// Each job passes a job slot and the write-back stage and its results the
// result queue, waiting while the port stalls. The line memories need no
// clearing after reset. Set frame_width and frame_height only between frames.
`default_nettype none

module separable_binomial_blur_3x3
   import sbb_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Configuration writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic                   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   // Sample requests; tdata: sample[15:0]
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // Results; tdata: blurred[15:0], out_row[29:16], out_col[41:30], zero[47:42]
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                        rsp_tlast
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WW  = CW + 1;
   localparam int OPW = $clog2(OUT_DEPTH);
   localparam int OCW = OPW + 2;

   typedef struct packed {
      logic [CW-1:0] col;
      logic [15:0]   h;
      logic [13:0]   row;
      logic          last_row;
      logic          final_col;
   } job_type;

   // Configuration registers
   logic [12:0] width_ff;
   logic [14:0] height_ff;

   // Raster position and horizontal taps
   logic [CW-1:0] col_ff, col_in;
   logic [13:0]   row_ff, row_in;
   logic [15:0]   prev_ff, prev_in, prev2_ff, prev2_in;

   // Pending column jobs
   job_type slot_a_ff, slot_a_in, slot_b_ff, slot_b_in;
   logic    a_vld_ff, a_vld_in, b_vld_ff, b_vld_in;

   // Write-back stage
   job_type     s2_job_ff;
   logic        s2_vld_ff, s2_fwd_ff;
   logic [15:0] fwd_older_ff, fwd_newer_ff;
   logic [15:0] rd_older_ff, rd_newer_ff;

   // Line memories
   logic [15:0] older_mem [MAX_WIDTH];
   logic [15:0] newer_mem [MAX_WIDTH];

   // Result queue
   res_type        fifo_mem [OUT_DEPTH];
   logic [OPW-1:0] wr_ff, rd_ff;
   logic [OPW:0]   cnt_ff;

   logic          accept, issue, room, pop;
   logic [WW-1:0] w_eff, col_nxt;
   logic [14:0]   h_eff, row_nxt;
   logic          end_row, last_row;
   logic [15:0]   cur;
   job_type       job0, job1;
   logic [15:0]   older_eff, newer_eff;
   res_type       res0, res1;
   logic          res0_v, res1_v;
   logic [OPW-1:0] wr1;

   assign csr_ready = 1'b1;
   assign cur       = req_tdata[15:0];

   // Clamp the frame size registers
   always_comb begin
      if (width_ff == 13'd0) begin
         w_eff = WW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      if (height_ff == 15'd0) begin
         h_eff = 15'd1;
      end else if (32'(height_ff) > 32'(ROW_LIMIT)) begin
         h_eff = 15'(ROW_LIMIT);
      end else begin
         h_eff = height_ff;
      end
   end

   assign col_nxt  = WW'(col_ff) + WW'(1);
   assign row_nxt  = {1'b0, row_ff} + 15'd1;
   assign end_row  = col_nxt >= w_eff;
   assign last_row = row_nxt >= h_eff;

   // Horizontal pass: jobs for the previous column and, at row end, this one
   always_comb begin
      job0.col       = col_ff - CW'(1);
      job0.h         = (col_ff == CW'(1)) ? avg2(prev_ff, cur) : avg121(prev2_ff, prev_ff, cur);
      job0.row       = row_ff;
      job0.last_row  = last_row;
      job0.final_col = 1'b0;
      job1.col       = col_ff;
      job1.h         = (col_ff == '0) ? cur : avg2(prev_ff, cur);
      job1.row       = row_ff;
      job1.last_row  = last_row;
      job1.final_col = 1'b1;
   end

   // Issue one job per cycle while the queue can take its results
   assign room = (OCW'(cnt_ff) + (s2_vld_ff ? OCW'(2) : OCW'(0)) + OCW'(2))
                 <= OCW'(OUT_DEPTH);
   assign issue      = a_vld_ff && room;
   assign req_tready = !a_vld_ff || (issue && !b_vld_ff);
   assign accept     = req_tvalid && req_tready;

   // Advance the raster position and job slots
   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      prev_in   = prev_ff;
      prev2_in  = prev2_ff;
      slot_a_in = slot_a_ff;
      slot_b_in = slot_b_ff;
      a_vld_in  = a_vld_ff;
      b_vld_in  = b_vld_ff;
      if (issue) begin
         slot_a_in = slot_b_ff;
         a_vld_in  = b_vld_ff;
         b_vld_in  = 1'b0;
      end
      if (accept) begin
         if (col_ff != '0) begin
            slot_a_in = job0;
            a_vld_in  = 1'b1;
            slot_b_in = job1;
            b_vld_in  = end_row;
         end else begin
            slot_a_in = job1;
            a_vld_in  = end_row;
            b_vld_in  = 1'b0;
         end
         if (end_row) begin
            col_in   = '0;
            prev_in  = '0;
            prev2_in = '0;
            row_in   = last_row ? 14'd0 : row_nxt[13:0];
         end else begin
            col_in   = col_nxt[CW-1:0];
            prev_in  = cur;
            prev2_in = prev_ff;
         end
      end
   end

   // Vertical pass on the column read back from the line memories
   assign older_eff = s2_fwd_ff ? fwd_older_ff : rd_older_ff;
   assign newer_eff = s2_fwd_ff ? fwd_newer_ff : rd_newer_ff;

   always_comb begin
      res0_v       = s2_vld_ff && (s2_job_ff.row != 14'd0);
      res0.blurred = (s2_job_ff.row == 14'd1) ? avg2(newer_eff, s2_job_ff.h)
                                              : avg121(older_eff, newer_eff, s2_job_ff.h);
      res0.row     = s2_job_ff.row - 14'd1;
      res0.col     = 12'(s2_job_ff.col);
      res0.done    = 1'b0;
      res1_v       = s2_vld_ff && s2_job_ff.last_row;
      res1.blurred = (s2_job_ff.row == 14'd0) ? s2_job_ff.h : avg2(newer_eff, s2_job_ff.h);
      res1.row     = s2_job_ff.row;
      res1.col     = 12'(s2_job_ff.col);
      res1.done    = s2_job_ff.final_col;
   end

   assign pop = rsp_tvalid && rsp_tready;
   assign wr1 = wr_ff + OPW'(1);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         col_ff    <= '0;
         row_ff    <= '0;
         prev_ff   <= '0;
         prev2_ff  <= '0;
         a_vld_ff  <= 1'b0;
         b_vld_ff  <= 1'b0;
         s2_vld_ff <= 1'b0;
         wr_ff     <= '0;
         rd_ff     <= '0;
         cnt_ff    <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_FRAME_WIDTH:  width_ff  <= csr_data[12:0];
               CSR_FRAME_HEIGHT: height_ff <= csr_data[14:0];
               default:          ;
            endcase
         end
         col_ff    <= col_in;
         row_ff    <= row_in;
         prev_ff   <= prev_in;
         prev2_ff  <= prev2_in;
         a_vld_ff  <= a_vld_in;
         b_vld_ff  <= b_vld_in;
         s2_vld_ff <= issue;
         wr_ff     <= wr_ff + OPW'(res0_v) + OPW'(res1_v);
         rd_ff     <= rd_ff + OPW'(pop);
         cnt_ff    <= cnt_ff + (OPW+1)'(res0_v) + (OPW+1)'(res1_v) - (OPW+1)'(pop);
      end
   end

   // Job payload and forwarding of a write to the column being read
   always_ff @(posedge clock) begin
      slot_a_ff <= slot_a_in;
      slot_b_ff <= slot_b_in;
      if (issue) begin
         s2_job_ff    <= slot_a_ff;
         s2_fwd_ff    <= s2_vld_ff && (s2_job_ff.col == slot_a_ff.col);
         fwd_older_ff <= newer_eff;
         fwd_newer_ff <= s2_job_ff.h;
      end
   end

   // Line memories: read at issue, write back in the cycle after
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_older_ff <= older_mem[slot_a_ff.col];
         rd_newer_ff <= newer_mem[slot_a_ff.col];
      end
      if (s2_vld_ff) begin
         older_mem[s2_job_ff.col] <= newer_eff;
         newer_mem[s2_job_ff.col] <= s2_job_ff.h;
      end
   end

   // Push results in order, upper row first
   always_ff @(posedge clock) begin
      if (res0_v) begin
         fifo_mem[wr_ff] <= res0;
      end
      if (res1_v) begin
         fifo_mem[res0_v ? wr1 : wr_ff] <= res1;
      end
   end

   // Drive the result port from the queue head
   assign rsp_tvalid = cnt_ff != '0;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, fifo_mem[rd_ff].col, fifo_mem[rd_ff].row,
                        fifo_mem[rd_ff].blurred};
   assign rsp_tlast  = fifo_mem[rd_ff].done;

endmodule

`default_nettype wire

/* design/sbb_checker.sv */
// ----------------------------------------------------------------------------
// Separable binomial blur port checker
// Watches the result port over time and binds to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "separable_binomial_blur_3x3_assert.svh"

module sbb_checker
   import sbb_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                   rsp_tlast
);

   // Hold a stalled result
   `SBB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // Drop all queued results on reset
   `SBB_ASSERT_NEXT_ANY(a_reset_empty, clock, reset, !rsp_tvalid)

   // Keep the unused top of tdata at zero
   `SBB_ASSERT_IMPLY(a_rsp_pad, clock, rsp_tvalid, rsp_tdata[RSP_TDATA_W-1:RSP_TDATA_W-RSP_PAD_W] == '0)

endmodule

bind separable_binomial_blur_3x3 sbb_checker u_sbb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
